@@ sv/tmpe_pkg.sv @@
// package: types, constants and address helpers for the tile map pixel engine
`timescale 1ns / 1ps
`default_nettype none

package tmpe_pkg;

   // geometry of the map and the tiles
   localparam int unsigned MAP_COLUMNS = 20;
   localparam int unsigned MAP_ROWS    = 15;
   localparam int unsigned TILE_SIDE   = 16;
   localparam int unsigned TILE_COUNT  = 16;

   localparam int unsigned SCREEN_WIDTH  = MAP_COLUMNS * TILE_SIDE;
   localparam int unsigned SCREEN_HEIGHT = MAP_ROWS * TILE_SIDE;

   // video ram layout
   localparam int unsigned VRAM_DEPTH = 4096;
   localparam int unsigned VRAM_AW    = $clog2(VRAM_DEPTH);
   localparam logic [VRAM_AW-1:0] MAP_BASE  = VRAM_AW'(12'h000);
   localparam logic [VRAM_AW-1:0] TILE_BASE = VRAM_AW'(12'h200);

   // operation codes
   typedef logic [1:0] op_type;
   localparam op_type OP_WRITE_BYTE  = 2'd0;
   localparam op_type OP_WRITE_PIXEL = 2'd1;
   localparam op_type OP_READ_PIXEL  = 2'd2;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RMW,
      ST_MAP,
      ST_PIX,
      ST_FLAG
   } state_type;

   // byte address of a pixel pair: base + tile * 128 + row * 8 + column / 2
   function automatic logic [VRAM_AW-1:0] tile_byte_addr(
      input logic [3:0] tile,
      input logic [3:0] row,
      input logic [2:0] pair
   );
      tile_byte_addr = TILE_BASE + VRAM_AW'({tile, row, pair});
   endfunction

   // byte address of the map entry covering a screen pixel
   function automatic logic [VRAM_AW-1:0] map_byte_addr(
      input logic [3:0] tile_row,
      input logic [4:0] tile_col
   );
      map_byte_addr = MAP_BASE + VRAM_AW'(tile_row * MAP_COLUMNS) + VRAM_AW'(tile_col);
   endfunction

endpackage

`default_nettype wire

@@ sv/tile_map_pixel_engine.sv @@
// top level: tile map video memory engine with a single 4 KiB video ram
`timescale 1ns / 1ps
`default_nettype none

// Tile map pixel engine. One item is processed at a time; req_ready is high
// while the sequencer is idle. A vram byte write is done on acceptance, a tile
// pixel write takes a read, then a merged write-back of the nibble, and a
// screen pixel read takes a map entry read, a tile byte read and a result
// load. A screen read outside the screen or through a map entry naming a
// missing tile ends with an out-of-range result, and a tile pixel write outside
// its tile is dropped. These steps come from the single read port of the video
// ram with a registered read and the dependent map-then-tile lookup. The result
// sits in an output register, so writes are still accepted while a result
// waits; a result load stalls until that register is free. The video ram has
// no reset and needs no clearing pass.
module tile_map_pixel_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire tmpe_pkg::op_type      req_operation,
   input  wire logic [11:0]           req_address,
   input  wire logic [7:0]            req_data,
   input  wire logic [7:0]            req_tile_number,
   input  wire logic [8:0]            req_x,
   input  wire logic [7:0]            req_y,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic [3:0]            rsp_color_index,
   output      logic                  rsp_out_of_range
);
   import tmpe_pkg::*;

   state_type state_ff, state_in;

   logic               req_accept;
   logic               out_free;

   // memory ports
   logic [7:0]         vram [VRAM_DEPTH];
   logic               mem_we, mem_re;
   logic [VRAM_AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]         mem_wdata;
   logic [7:0]         rd_data_ff;

   // item registers
   logic [VRAM_AW-1:0] addr_ff, addr_in;
   logic [3:0]         color_ff, color_in;
   logic [3:0]         px_ff, px_in;
   logic [3:0]         py_ff, py_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [3:0]         rsp_color_ff, rsp_color_in;
   logic               rsp_oor_ff, rsp_oor_in;
   logic               rsp_load;

   // decoded request checks
   logic               pixel_in_tile;
   logic               pixel_on_screen;
   logic               entry_valid;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign pixel_in_tile   = (32'(req_tile_number) < TILE_COUNT) &&
                            (32'(req_x) < TILE_SIDE) && (32'(req_y) < TILE_SIDE);
   assign pixel_on_screen = (32'(req_x) < SCREEN_WIDTH) && (32'(req_y) < SCREEN_HEIGHT);
   assign entry_valid     = (32'(rd_data_ff) < TILE_COUNT);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff) inside
         ST_IDLE: begin
            if (req_accept) begin
               if (req_operation == OP_WRITE_PIXEL && pixel_in_tile) begin
                  state_in = ST_RMW;
               end else if (req_operation == OP_READ_PIXEL) begin
                  state_in = pixel_on_screen ? ST_MAP : ST_FLAG;
               end
            end
         end
         ST_RMW: state_in = ST_IDLE;
         ST_MAP: begin
            if (entry_valid) begin
               state_in = ST_PIX;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_PIX, ST_FLAG: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memory controls, item capture and result load
   always_comb begin
      mem_we       = 1'b0;
      mem_waddr    = req_address;
      mem_wdata    = req_data;
      mem_re       = 1'b0;
      mem_raddr    = tile_byte_addr(req_tile_number[3:0], req_y[3:0], req_x[3:1]);
      addr_in      = addr_ff;
      color_in     = color_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      rsp_load     = 1'b0;
      rsp_color_in = 4'd0;
      rsp_oor_in   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               addr_in  = tile_byte_addr(req_tile_number[3:0], req_y[3:0], req_x[3:1]);
               color_in = req_data[3:0];
               px_in    = req_x[3:0];
               py_in    = req_y[3:0];
               case (req_operation)
                  OP_WRITE_BYTE: mem_we = 1'b1;
                  OP_WRITE_PIXEL: mem_re = pixel_in_tile;
                  OP_READ_PIXEL: begin
                     mem_re    = pixel_on_screen;
                     mem_raddr = map_byte_addr(req_y[7:4], req_x[8:4]);
                  end
                  default: ;
               endcase
            end
         end
         ST_RMW: begin
            // merge the new nibble into the byte just read
            mem_we    = 1'b1;
            mem_waddr = addr_ff;
            mem_wdata = px_ff[0] ? {color_ff, rd_data_ff[3:0]}
                                 : {rd_data_ff[7:4], color_ff};
         end
         ST_MAP: begin
            if (entry_valid) begin
               mem_re    = 1'b1;
               mem_raddr = tile_byte_addr(rd_data_ff[3:0], py_ff, px_ff[3:1]);
            end else begin
               rsp_load = out_free;
            end
         end
         ST_PIX: begin
            rsp_load     = out_free;
            rsp_color_in = px_ff[0] ? rd_data_ff[7:4] : rd_data_ff[3:0];
            rsp_oor_in   = 1'b0;
         end
         ST_FLAG: rsp_load = out_free;
         default: ;
      endcase
   end

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      color_ff <= color_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      if (rsp_load) begin
         rsp_color_ff <= rsp_color_in;
         rsp_oor_ff   <= rsp_oor_in;
      end
   end

   // video ram: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         vram[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= vram[mem_raddr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_color_index  = rsp_color_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   // an in-range tile pixel write always goes to the write-back step
   a_rmw_follows: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_operation == OP_WRITE_PIXEL && pixel_in_tile |=> state_ff == ST_RMW)
      else $error("pixel write did not enter write-back");

   // write-back writes the memory and issues no read
   a_rmw_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RMW |-> mem_we && !mem_re)
      else $error("write-back step without a write");

   // a result appears only after a read or flag step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |->
         $past(state_ff) == ST_PIX || $past(state_ff) == ST_MAP || $past(state_ff) == ST_FLAG)
      else $error("result without a screen read");

endmodule

`default_nettype wire
